### rtl/tlp_pkg.sv
// ----------------------------------------------------------------------------
// tlp_pkg
// Shared types, constants and the hex decode helper for the tag-length
// list parser.
// ----------------------------------------------------------------------------
package tlp_pkg;

  // Parse position inside one tag-length entry
  typedef enum logic [1:0] {
    PH_TAG_FIRST = 2'd0,
    PH_TAG_MORE  = 2'd1,
    PH_LEN_FIRST = 2'd2,
    PH_LEN_MORE  = 2'd3
  } phase_e;

  localparam int unsigned TagValueW  = 32;
  localparam int unsigned TagCountW  = 3;
  localparam int unsigned LengthW    = 16;
  localparam int unsigned EntryNumW  = 6;
  localparam int unsigned CharW      = 8;

  // Result item payload, lowest field first in tdata
  localparam int unsigned ResultW    = TagValueW + TagCountW + LengthW + EntryNumW;
  localparam int unsigned ResultBusW = ((ResultW + 7) / 8) * 8;

  localparam logic [4:0]         TagMoreMark = 5'h1F;
  localparam logic [LengthW-1:0] LenShortMax = 16'h00FF;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decode one ASCII hex digit, either case
  function automatic hex_t hex_decode(input logic [CharW-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

### rtl/tag_length_list_parser.sv
// ----------------------------------------------------------------------------
// tag_length_list_parser
// Parses an ASCII-hex character stream holding a BER-TLV style tag-length
// list and emits one item per completed tag and length, or an error item.
// ----------------------------------------------------------------------------
//
// Channel   | Dir | tdata                         | tuser         | tlast
// ----------+-----+-------------------------------+---------------+-----------
// s_axis    | in  | [7:0] hex_char                | -             | last_char
// m_axis    | out | tag_value, tag_byte_count,    | format_error  | -
//           |     | length_value, entry_number    |               |
//
// One character item per cycle is accepted sustained while m_axis does not
// stall; each character passes the input register, then decode and state
// update into the result register. The state update of one character is a
// single step, which is what sets the rate of one item per cycle.
// Reset (rst_ni low, asynchronous) returns the parser to the start of a tag,
// clears the entry count and empties both registers.
// A stall on m_axis holds the result register and, through it, the input
// register; s_axis_tready drops only while both are full and blocked.
// ----------------------------------------------------------------------------
module tag_length_list_parser #(
  parameter int unsigned MAX_TAG_BYTES    = 4,
  parameter int unsigned MAX_LENGTH_BYTES = 2,
  parameter int unsigned MAX_ENTRIES      = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Character items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tlp_pkg::CharW-1:0]       s_axis_tdata,   // [7:0] hex_char
  input  logic                            s_axis_tlast,   // last_char
  // Result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] tag_value, [34:32] tag_byte_count, [50:35] length_value,
  // [56:51] entry_number, [63:57] zero
  output logic [tlp_pkg::ResultBusW-1:0]  m_axis_tdata,
  output logic                            m_axis_tuser    // [0] format_error
);
  import tlp_pkg::*;

  localparam int unsigned TbW  = $clog2(MAX_TAG_BYTES + 1);
  localparam int unsigned LbW  = $clog2(MAX_LENGTH_BYTES + 1);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES);
  localparam int unsigned TbXW  = (TbW > TagCountW) ? TbW : TagCountW;
  localparam int unsigned CntXW = (CntW > EntryNumW) ? CntW : EntryNumW;

  // Input register
  logic             in_vld_q;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;

  // Parse state
  phase_e              phase_q, phase_d;
  logic                nib_seen_q, nib_seen_d;
  logic [3:0]          hi_nib_q, hi_nib_d;
  logic [TagValueW-1:0] tag_q, tag_d;
  logic [TbW-1:0]      tag_cnt_q, tag_cnt_d;
  logic [LengthW-1:0]  len_q, len_d;
  logic [LbW-1:0]      len_left_q, len_left_d;
  logic [CntW-1:0]     entry_q, entry_d;

  // Result register
  logic                  out_vld_q;
  logic [ResultBusW-1:0] out_data_q, out_data_d;
  logic                  out_err_q, out_err_d;

  logic out_free, step;
  logic emit, fail;
  logic [LengthW-1:0] emit_len;
  hex_t               hx;
  logic [7:0]         byte_v;
  logic [6:0]         len_n;
  logic [LengthW-1:0] len_shift;
  logic [LbW-1:0]     left_dec;
  logic [TbXW-1:0]    tag_cnt_x;
  logic [CntXW-1:0]   entry_x;

  // The result register may take a new value when empty or being drained
  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  assign tag_cnt_x = TbXW'(tag_cnt_q);
  assign entry_x   = CntXW'(entry_q);

  always_comb begin
    hx         = hex_decode(in_char_q);
    byte_v     = {hi_nib_q, hx.val};
    len_n      = byte_v[6:0];
    len_shift  = {len_q[7:0], byte_v};
    left_dec   = (len_left_q != '0) ? len_left_q - LbW'(1) : len_left_q;

    phase_d    = phase_q;
    nib_seen_d = nib_seen_q;
    hi_nib_d   = hi_nib_q;
    tag_d      = tag_q;
    tag_cnt_d  = tag_cnt_q;
    len_d      = len_q;
    len_left_d = len_left_q;
    entry_d    = entry_q;
    emit       = 1'b0;
    fail       = 1'b0;
    emit_len   = '0;

    if (!hx.ok) begin
      fail = 1'b1;
    end else if (!nib_seen_q) begin
      // Hold the high nibble until its partner arrives
      hi_nib_d   = hx.val;
      nib_seen_d = 1'b1;
    end else begin
      nib_seen_d = 1'b0;
      unique case (phase_q)
        PH_TAG_FIRST: begin
          tag_d     = TagValueW'(byte_v);
          tag_cnt_d = TbW'(1);
          phase_d   = (byte_v[4:0] == TagMoreMark) ? PH_TAG_MORE : PH_LEN_FIRST;
        end
        PH_TAG_MORE: begin
          if (tag_cnt_q >= TbW'(MAX_TAG_BYTES)) begin
            fail = 1'b1;
          end else begin
            tag_d     = {tag_q[TagValueW-9:0], byte_v};
            tag_cnt_d = tag_cnt_q + TbW'(1);
            if (!byte_v[7]) begin
              phase_d = PH_LEN_FIRST;
            end
          end
        end
        PH_LEN_FIRST: begin
          if (!byte_v[7]) begin
            emit     = 1'b1;
            emit_len = LengthW'(byte_v);
          end else if (len_n == 7'd0 || len_n > 7'(MAX_LENGTH_BYTES)) begin
            fail = 1'b1;
          end else begin
            len_d      = '0;
            len_left_d = LbW'(len_n);
            phase_d    = PH_LEN_MORE;
          end
        end
        PH_LEN_MORE: begin
          // Drop the entry once the value would pass 16 bits
          if (len_q > LenShortMax) begin
            fail = 1'b1;
          end else if (left_dec == '0) begin
            emit     = 1'b1;
            emit_len = len_shift;
          end else begin
            len_d      = len_shift;
            len_left_d = left_dec;
          end
        end
        default: fail = 1'b1;
      endcase
    end

    // Result payload for this character
    if (fail) begin
      out_data_d = ResultBusW'({entry_x[EntryNumW-1:0], LengthW'(0), TagCountW'(0),
                               TagValueW'(0)});
    end else begin
      out_data_d = ResultBusW'({entry_x[EntryNumW-1:0], emit_len,
                               tag_cnt_x[TagCountW-1:0], tag_q});
    end
    out_err_d = fail;

    if (emit) begin
      entry_d = (entry_q == CntW'(MAX_ENTRIES - 1)) ? '0 : entry_q + CntW'(1);
    end

    // Restart the entry after any result or at the end of the string
    if (fail || emit || in_last_q) begin
      phase_d    = PH_TAG_FIRST;
      nib_seen_d = 1'b0;
      hi_nib_d   = '0;
      tag_d      = '0;
      tag_cnt_d  = '0;
      len_d      = '0;
      len_left_d = '0;
    end
    if (in_last_q) begin
      entry_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      phase_q    <= PH_TAG_FIRST;
      nib_seen_q <= 1'b0;
      hi_nib_q   <= '0;
      tag_q      <= '0;
      tag_cnt_q  <= '0;
      len_q      <= '0;
      len_left_q <= '0;
      entry_q    <= '0;
    end else begin
      // Advance the input register
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      // Update parse state and the result valid flag
      if (step) begin
        phase_q    <= phase_d;
        nib_seen_q <= nib_seen_d;
        hi_nib_q   <= hi_nib_d;
        tag_q      <= tag_d;
        tag_cnt_q  <= tag_cnt_d;
        len_q      <= len_d;
        len_left_q <= len_left_d;
        entry_q    <= entry_d;
        out_vld_q  <= emit || fail;
      end else if (m_axis_tready) begin
        out_vld_q  <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (step && (emit || fail)) begin
      out_data_q <= out_data_d;
      out_err_q  <= out_err_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tag-length list parser. Characters go in over
// the slave stream and entries come back over the master stream, with random
// stalls on both sides. A short directed table runs first. Random lists
// follow: mostly well-formed tag-length entries in random hex case, mixed
// with non-hex characters, overlong tags, bad length counts, dropped nibbles
// and lists cut off in the middle of an entry. Every result is checked field
// by field against a cycle-free model of the parser kept in this file.
// ----------------------------------------------------------------------------
module testbench;
  import tlp_pkg::*;

  // Parser configuration; the instance below uses the same values
  localparam int unsigned TagBytesMax = 4;
  localparam int unsigned LenBytesMax = 2;
  localparam int unsigned EntryMax    = 64;

  localparam int RandItems     = 1450;
  localparam int WatchdogLimit = 2000;  // cycles without any handshake
  localparam int DrainCycles   = 8;     // margin after the last owed result
  localparam int QuietFrom     = 600;   // no idling on either side in here
  localparam int QuietTo       = 1100;
  localparam int PrintCap      = 100;

  // One decoded entry as it leaves the parser
  typedef struct packed {
    logic [TagValueW-1:0] tag_value;
    logic [TagCountW-1:0] tag_bytes;
    logic [LengthW-1:0]   length_value;
    logic [EntryNumW-1:0] entry_number;
    logic                 format_error;
  } entry_t;

  // One character item; typed rows carry their own expected entry
  typedef struct packed {
    logic [CharW-1:0] c;
    logic             last;
    logic             typed;
    entry_t           res;
  } char_item_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [CharW-1:0]      s_axis_tdata  = '0;   // [7:0] hex_char
  logic                  s_axis_tlast  = 1'b0; // last_char
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [31:0] tag_value, [34:32] tag_byte_count, [50:35] length_value,
  // [56:51] entry_number, [63:57] zero
  logic [ResultBusW-1:0] m_axis_tdata;
  logic                  m_axis_tuser;         // [0] format_error

  tag_length_list_parser #(
    .MAX_TAG_BYTES    (TagBytesMax),
    .MAX_LENGTH_BYTES (LenBytesMax),
    .MAX_ENTRIES      (EntryMax)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Bookkeeping
  // --------------------------------------------------------------------------
  char_item_t char_q[$];          // characters waiting to be sent
  char_item_t build_q[$];         // list under construction
  entry_t     pending_entries[$]; // entries the parser still owes us
  int         cyc;
  int         queued_chars;
  int         mismatches;
  int         chars_sent;
  int         lists_sent;
  int         results_seen;
  int         error_results;
  int         top_entry;
  bit         timed_out;

  always @(posedge clk_i) cyc <= cyc + 1;

  // Idle about a quarter of the cycles, except inside the quiet window
  function automatic bit side_idles();
    if (cyc >= QuietFrom && cyc <= QuietTo) return 1'b0;
    return $urandom_range(0, 99) < 25;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= PrintCap) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input int idx);
    if (got !== want) begin
      report($sformatf("result %0d %s got 0x%0h want 0x%0h", idx, name, got, want));
    end
  endtask

  // ASCII hex digit to nibble; returns 0 for anything else
  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= "0" && c <= "9") begin
      v = c[3:0];
      return 1'b1;
    end
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      v = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Parser model: state, then one step per accepted character
  // --------------------------------------------------------------------------
  phase_e               ph;
  logic                 half_seen;
  logic [3:0]           hi_nib;
  logic [TagValueW-1:0] tag_acc;
  logic [TagCountW-1:0] tag_cnt;
  logic [LengthW-1:0]   len_acc;
  logic [1:0]           len_left;
  logic [EntryNumW-1:0] entry_cnt;

  task automatic restart_entry();
    ph        = PH_TAG_FIRST;
    half_seen = 1'b0;
    hi_nib    = '0;
    tag_acc   = '0;
    tag_cnt   = '0;
    len_acc   = '0;
    len_left  = '0;
  endtask

  task automatic parse_char(input logic [7:0] c, input logic last,
                            output logic got, output entry_t res);
    logic [3:0]         v;
    logic [7:0]         b;
    logic [6:0]         n;
    logic               fail;
    logic               done;
    logic [LengthW-1:0] len;
    got  = 1'b0;
    res  = '0;
    fail = 1'b0;
    done = 1'b0;
    len  = '0;
    if (!hex_nibble(c, v)) begin
      // a non-hex character also drops a pending half byte
      fail = 1'b1;
    end else if (!half_seen) begin
      hi_nib    = v;
      half_seen = 1'b1;
    end else begin
      half_seen = 1'b0;
      b         = {hi_nib, v};
      n         = b[6:0];
      case (ph)
        PH_TAG_FIRST: begin
          tag_acc = {24'h0, b};
          tag_cnt = 3'd1;
          ph      = (b[4:0] == TagMoreMark) ? PH_TAG_MORE : PH_LEN_FIRST;
        end
        PH_TAG_MORE: begin
          if (tag_cnt >= TagBytesMax) begin
            fail = 1'b1;
          end else begin
            tag_acc = {tag_acc[23:0], b};
            tag_cnt = tag_cnt + 3'd1;
            if (!b[7]) ph = PH_LEN_FIRST;
          end
        end
        PH_LEN_FIRST: begin
          if (!b[7]) begin
            done = 1'b1;
            len  = {8'h0, b};
          end else if (n == 0 || n > LenBytesMax) begin
            fail = 1'b1;
          end else begin
            len_acc  = '0;
            len_left = 2'(n);
            ph       = PH_LEN_MORE;
          end
        end
        default: begin
          if (len_acc > LenShortMax) begin
            fail = 1'b1;
          end else begin
            len_acc = {len_acc[7:0], b};
            if (len_left != 0) len_left = len_left - 2'd1;
            if (len_left == 0) begin
              done = 1'b1;
              len  = len_acc;
            end
          end
        end
      endcase
    end
    if (fail) begin
      got = 1'b1;
      res = '{32'h0, 3'd0, 16'h0, entry_cnt, 1'b1};
      restart_entry();
    end else if (done) begin
      got       = 1'b1;
      res       = '{tag_acc, tag_cnt, len, entry_cnt, 1'b0};
      entry_cnt = (entry_cnt == EntryNumW'(EntryMax - 1)) ? '0 : entry_cnt + 1'b1;
      restart_entry();
    end
    // end of string: drop any partial entry and number the next list from 0
    if (last) begin
      restart_entry();
      entry_cnt = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  task automatic push_char(input logic [7:0] c);
    build_q.insert(build_q.size(), '{c, 1'b0, 1'b0, '0});
  endtask

  // High nibble first, letters in random case
  task automatic push_byte(input logic [7:0] b);
    logic [3:0] nib;
    logic [7:0] ch;
    for (int k = 1; k >= 0; k--) begin
      nib = b[k*4 +: 4];
      if (nib < 4'd10) ch = 8'h30 + 8'(nib);
      else ch = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
      push_char(ch);
    end
  endtask

  // Any non-hex code, often one just outside a hex range
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    logic [3:0] v;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0:       c = 8'h2F;
        1:       c = 8'h3A;
        2:       c = 8'h40;
        3:       c = 8'h47;
        4:       c = 8'h60;
        default: c = 8'h67;
      endcase
      return c;
    end
    do c = 8'($urandom); while (hex_nibble(c, v));
    return c;
  endfunction

  // One entry; plain ones are a one-byte tag with a short length
  task automatic gen_entry(input bit plain);
    int         kind;
    int         tlen;
    int         start;
    logic [7:0] b;
    start = build_q.size();
    kind  = plain ? 99 : $urandom_range(0, 99);
    if (kind < 6) begin
      // overlong tag: four continuing bytes, the fifth trips the limit
      push_byte({3'($urandom), TagMoreMark});
      repeat (3) push_byte({1'b1, 7'($urandom)});
      push_byte(8'($urandom));
      return;
    end
    tlen = plain ? 1 : $urandom_range(1, TagBytesMax);
    b    = 8'($urandom);
    if (tlen == 1) begin
      if (b[4:0] == TagMoreMark) b[0] = 1'b0;
    end else begin
      b[4:0] = TagMoreMark;
    end
    push_byte(b);
    for (int k = 2; k <= tlen; k++) push_byte({k != tlen, 7'($urandom)});
    case (plain ? 0 : $urandom_range(0, 9))
      0, 1, 2, 3, 4: push_byte({1'b0, 7'($urandom)});
      5, 6: begin
        push_byte(8'h81);
        push_byte(8'($urandom));
      end
      7, 8: begin
        push_byte(8'h82);
        push_byte(8'($urandom));
        push_byte(8'($urandom));
      end
      default: push_byte($urandom_range(0, 1) ? 8'h80 : 8'($urandom_range(8'h83, 8'hFF)));
    endcase
    if (kind < 12) begin
      build_q.insert($urandom_range(start, build_q.size() - 1),
                     '{noise_char(), 1'b0, 1'b0, '0});
    end else if (kind < 15) begin
      // lose one nibble so the rest of the entry is misaligned
      build_q.delete($urandom_range(start, build_q.size() - 1));
    end
  endtask

  // One list ending in last_char, sometimes cut inside its final entry
  task automatic gen_list(input int n, input bit plain);
    build_q.delete();
    repeat (n) gen_entry(plain);
    if (!plain && $urandom_range(0, 9) == 0 && build_q.size() > 3) begin
      repeat ($urandom_range(1, 3)) void'(build_q.pop_back());
    end
    build_q[build_q.size() - 1].last = 1'b1;
    char_q = {char_q, build_q};
    queued_chars += build_q.size();
  endtask

  // --------------------------------------------------------------------------
  // Character side: predict on accept, then present the next item
  // --------------------------------------------------------------------------
  char_item_t cur_item;

  always @(posedge clk_i) begin : char_side
    logic   got;
    entry_t pred;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_char(s_axis_tdata, s_axis_tlast, got, pred);
        // typed rows hold the value to check; the model fills in the rest
        if (cur_item.typed) pending_entries.insert(pending_entries.size(), cur_item.res);
        else if (got) pending_entries.insert(pending_entries.size(), pred);
        chars_sent++;
        if (s_axis_tlast) lists_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (char_q.size() != 0 && !side_idles()) begin
          cur_item = char_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_item.c;
          s_axis_tlast  <= cur_item.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: compare with the oldest owed entry, stall at random
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_side
    entry_t seen;
    entry_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = '{m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tdata[50:35],
                 m_axis_tdata[56:51], m_axis_tuser};
        if (pending_entries.size() == 0) begin
          report($sformatf("result %0d arrived with nothing owed", results_seen));
        end else begin
          want = pending_entries.pop_front();
          check_field("tag_value", seen.tag_value, want.tag_value, results_seen);
          check_field("tag_byte_count", 32'(seen.tag_bytes), 32'(want.tag_bytes),
                      results_seen);
          check_field("length_value", 32'(seen.length_value), 32'(want.length_value),
                      results_seen);
          check_field("entry_number", 32'(seen.entry_number), 32'(want.entry_number),
                      results_seen);
          check_field("format_error", 32'(seen.format_error), 32'(want.format_error),
                      results_seen);
        end
        results_seen++;
        if (seen.format_error) error_results++;
        if (int'(seen.entry_number) > top_entry) top_entry = int'(seen.entry_number);
      end
      m_axis_tready <= !side_idles();
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed table, random lists, drain, verdict
  // --------------------------------------------------------------------------
  initial begin : main_seq
    char_item_t dir_tab[$];
    dir_tab = '{
      // top code, not hex: error on the very first item
      '{8'hFF, 1'b0, 1'b1, '{32'h0, 3'd0, 16'h0, 6'd0, 1'b1}},
      // tag DF FF FF FF then a fifth byte: overlong tag
      '{"D", 1'b0, 1'b0, '0}, '{"F", 1'b0, 1'b0, '0},
      '{"F", 1'b0, 1'b0, '0}, '{"F", 1'b0, 1'b0, '0},
      '{"F", 1'b0, 1'b0, '0}, '{"F", 1'b0, 1'b0, '0},
      '{"F", 1'b0, 1'b0, '0}, '{"F", 1'b0, 1'b0, '0},
      '{"0", 1'b0, 1'b0, '0},
      '{"0", 1'b0, 1'b1, '{32'h0, 3'd0, 16'h0, 6'd0, 1'b1}},
      // tag 5A, long form 82 FF FF: largest length
      '{"5", 1'b0, 1'b0, '0}, '{"a", 1'b0, 1'b0, '0},
      '{"8", 1'b0, 1'b0, '0}, '{"2", 1'b0, 1'b0, '0},
      '{"F", 1'b0, 1'b0, '0}, '{"F", 1'b0, 1'b0, '0},
      '{"f", 1'b0, 1'b0, '0},
      '{"F", 1'b0, 1'b1, '{32'h5A, 3'd1, 16'hFFFF, 6'd0, 1'b0}},
      // tag 00, length 80: indefinite form
      '{"0", 1'b0, 1'b0, '0}, '{"0", 1'b0, 1'b0, '0},
      '{"8", 1'b0, 1'b0, '0},
      '{"0", 1'b0, 1'b1, '{32'h0, 3'd0, 16'h0, 6'd1, 1'b1}},
      // tag 3E, length 83: more length bytes than allowed
      '{"3", 1'b0, 1'b0, '0}, '{"E", 1'b0, 1'b0, '0},
      '{"8", 1'b0, 1'b0, '0},
      '{"3", 1'b0, 1'b1, '{32'h0, 3'd0, 16'h0, 6'd1, 1'b1}},
      // tag 9F01, short length 7F, closing the list
      '{"9", 1'b0, 1'b0, '0}, '{"f", 1'b0, 1'b0, '0},
      '{"0", 1'b0, 1'b0, '0}, '{"1", 1'b0, 1'b0, '0},
      '{"7", 1'b0, 1'b0, '0},
      '{"F", 1'b1, 1'b1, '{32'h9F01, 3'd2, 16'h7F, 6'd1, 1'b0}},
      // tag 12 with no length, cut by end of string, dropped silently
      '{"1", 1'b0, 1'b0, '0}, '{"2", 1'b1, 1'b0, '0},
      // code zero: error numbered from a fresh list
      '{8'h00, 1'b0, 1'b1, '{32'h0, 3'd0, 16'h0, 6'd0, 1'b1}}
    };

    restart_entry();
    entry_cnt = '0;
    rst_ni    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    char_q = {char_q, dir_tab};
    // one long plain list to carry the entry number through its wrap
    gen_list(EntryMax + 6, 1'b1);
    while (queued_chars < RandItems) gen_list($urandom_range(1, 12), 1'b0);

    fork
      begin
        while (char_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
        while (pending_entries.size() != 0) @(posedge clk_i);
        repeat (DrainCycles) @(posedge clk_i);
      end
      begin : watchdog
        int idle;
        idle = 0;
        while (idle < WatchdogLimit) begin
          @(posedge clk_i);
          if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle = 0;
          end else begin
            idle++;
          end
        end
        timed_out = 1'b1;
      end
    join_any

    if (timed_out) begin
      $display("Watchdog: no handshake for %0d cycles", WatchdogLimit);
    end else if (pending_entries.size() != 0) begin
      report($sformatf("%0d entries never arrived", pending_entries.size()));
    end
    $display("Sent %0d characters in %0d lists; checked %0d results, %0d of them errors",
             chars_sent, lists_sent, results_seen, error_results);
    $display("Highest entry number seen %0d; %0d mismatches", top_entry, mismatches);
    if (!timed_out && mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
